// ===== hdl/linear_scan_min_priority_queue_core_defines.svh =====
// Assertion macros shared by the priority queue RTL.
`ifndef LINEAR_SCAN_MIN_PRIORITY_QUEUE_CORE_DEFINES_SVH
`define LINEAR_SCAN_MIN_PRIORITY_QUEUE_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define LSMPQ_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("lsmpq assertion failed");

// Next-cycle implication, disabled during reset.
`define LSMPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("lsmpq assertion failed");

`endif

// ===== hdl/lsmpq_pkg.sv =====
// Types and constants of the linear-scan minimum priority queue.
package lsmpq_pkg;

    localparam int DEF_CAPACITY    = 64;
    localparam int DEF_VERTEX_BITS = 16;
    localparam int DIST_BITS       = 32;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_REMOVED  = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_COMP = 4'b0100,
        S_RESP = 4'b1000
    } t_state;

    typedef struct packed {
        logic en;
        logic first;
    } t_scan_ctl;

endpackage

// ===== hdl/lsmpq_mem.sv =====
// Entry store: one write port, one registered read port.
module lsmpq_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 48
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hdl/lsmpq_scan_unit.sv =====
// Signed compare unit that tracks the minimum entry over a scan.
module lsmpq_scan_unit #(
    parameter int CAPACITY    = lsmpq_pkg::DEF_CAPACITY,
    parameter int VERTEX_BITS = lsmpq_pkg::DEF_VERTEX_BITS
) (
    input  logic                                 i_clk,
    input  lsmpq_pkg::t_scan_ctl                 i_ctl,
    input  logic [$clog2(CAPACITY)-1:0]          i_idx,
    input  logic [VERTEX_BITS-1:0]               i_vertex,
    input  logic signed [lsmpq_pkg::DIST_BITS-1:0] i_distance,
    output logic [$clog2(CAPACITY)-1:0]          o_best_idx,
    output logic [VERTEX_BITS-1:0]               o_best_vertex,
    output logic signed [lsmpq_pkg::DIST_BITS-1:0] o_best_distance
);
    import lsmpq_pkg::*;

    localparam int AW = $clog2(CAPACITY);

    logic [AW-1:0]               r_best_idx;
    logic [VERTEX_BITS-1:0]      r_best_vertex;
    logic signed [DIST_BITS-1:0] r_best_distance;
    logic                        w_take;

    // Newer entries win ties.
    assign w_take = i_ctl.en && (i_ctl.first || (i_distance <= r_best_distance));

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_best_idx      <= i_idx;
            r_best_vertex   <= i_vertex;
            r_best_distance <= i_distance;
        end
    end

    assign o_best_idx      = r_best_idx;
    assign o_best_vertex   = r_best_vertex;
    assign o_best_distance = r_best_distance;
endmodule

// ===== hdl/linear_scan_min_priority_queue_core.sv =====
// Insert: written to the store, result registered in S_RESP. A new request is
// taken only in S_IDLE. Remove of the minimum: the scan reads one entry a cycle
// through the compare unit, then the compaction reads the later entries and
// shifts each down one slot. Remove on empty or insert on full skips the store.
// Reset clears the entry count and handshakes; store contents stay undefined.
`include "linear_scan_min_priority_queue_core_defines.svh"
module linear_scan_min_priority_queue_core #(
    parameter int CAPACITY    = lsmpq_pkg::DEF_CAPACITY,
    parameter int VERTEX_BITS = lsmpq_pkg::DEF_VERTEX_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // vertex_id[15:0], key_distance[47:16]
    input  logic [0:0]  s_axis_tuser,   // operation[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // out_vertex[15:0], out_distance[47:16],
                                        // entry_total[54:48], is_vacant[55]
    output logic [1:0]  m_axis_tuser    // status[1:0]
);
    import lsmpq_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int MW = VERTEX_BITS + DIST_BITS;
    localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

    t_state        r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_idx, n_idx;
    logic          r_rd_v, n_rd_v;
    logic [AW-1:0] r_rd_idx, n_rd_idx;
    t_status       r_status, n_status;
    logic          r_m_valid, n_m_valid;
    logic [1:0]    r_m_user, n_m_user;
    logic [55:0]   r_m_data, n_m_data;

    logic          w_accept;
    logic          w_we, w_re;
    logic [AW-1:0] w_waddr, w_raddr;
    logic [MW-1:0] w_wdata, w_rdata;
    t_scan_ctl     w_scan;
    logic [AW-1:0]               w_best_idx;
    logic [VERTEX_BITS-1:0]      w_best_vertex;
    logic signed [DIST_BITS-1:0] w_best_distance;
    logic [15:0]                 w_res_vertex;
    logic [DIST_BITS-1:0]        w_res_distance;

    lsmpq_mem #(
        .DEPTH (CAPACITY),
        .WIDTH (MW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    lsmpq_scan_unit #(
        .CAPACITY    (CAPACITY),
        .VERTEX_BITS (VERTEX_BITS)
    ) u_scan (
        .i_clk           (i_clk),
        .i_ctl           (w_scan),
        .i_idx           (r_rd_idx),
        .i_vertex        (w_rdata[VERTEX_BITS-1:0]),
        .i_distance      (w_rdata[MW-1:VERTEX_BITS]),
        .o_best_idx      (w_best_idx),
        .o_best_vertex   (w_best_vertex),
        .o_best_distance (w_best_distance)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_scan.en     = (r_state == S_SCAN) && r_rd_v;
    assign w_scan.first  = (r_rd_idx == '0);

    assign w_res_vertex   = (r_status == ST_REMOVED) ? 16'(w_best_vertex) : 16'd0;
    assign w_res_distance = (r_status == ST_REMOVED) ? w_best_distance : '0;

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_idx     = r_idx;
        n_rd_v    = 1'b0;
        n_rd_idx  = r_rd_idx;
        n_status  = r_status;
        n_m_valid = r_m_valid && !m_axis_tready;
        n_m_user  = r_m_user;
        n_m_data  = r_m_data;
        w_we      = 1'b0;
        w_waddr   = r_count[AW-1:0];
        w_wdata   = {s_axis_tdata[47:16], VERTEX_BITS'(s_axis_tdata[15:0])};
        w_re      = 1'b0;
        w_raddr   = r_idx[AW-1:0];

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_RESP;
                    if (s_axis_tuser[0] == OP_INSERT) begin
                        if (r_count == CAP_CNT) begin
                            n_status = ST_FULL;
                        end else begin
                            w_we     = 1'b1;
                            n_count  = r_count + CW'(1);
                            n_status = ST_INSERTED;
                        end
                    end else if (r_count == '0) begin
                        n_status = ST_EMPTY;
                    end else begin
                        n_state = S_SCAN;
                        n_idx   = '0;
                    end
                end
            end
            S_SCAN, S_COMP: begin
                if (r_idx != r_count) begin
                    w_re     = 1'b1;
                    n_idx    = r_idx + CW'(1);
                    n_rd_v   = 1'b1;
                    n_rd_idx = r_idx[AW-1:0];
                end
                if (r_state == S_COMP && r_rd_v) begin
                    // shift the later entry down one slot
                    w_we    = 1'b1;
                    w_waddr = r_rd_idx - AW'(1);
                    w_wdata = w_rdata;
                end
                if (r_idx == r_count && !r_rd_v) begin
                    if (r_state == S_SCAN) begin
                        n_state = S_COMP;
                        n_idx   = CW'(w_best_idx) + CW'(1);
                    end else begin
                        n_state  = S_RESP;
                        n_count  = r_count - CW'(1);
                        n_status = ST_REMOVED;
                    end
                end
            end
            S_RESP: begin
                if (!r_m_valid || m_axis_tready) begin
                    n_m_valid = 1'b1;
                    n_m_user  = r_status;
                    n_m_data  = {(r_count == '0), 7'(r_count), w_res_distance, w_res_vertex};
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_rd_v    <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_rd_v    <= n_rd_v;
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_rd_idx <= n_rd_idx;
        r_status <= n_status;
        r_m_user <= n_m_user;
        r_m_data <= n_m_data;
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tuser  = r_m_user;
    assign m_axis_tdata  = r_m_data;

    `LSMPQ_ASSERT_IMPL(a_count_max, i_clk, i_rst_n, 1'b1, r_count <= CAP_CNT)
    `LSMPQ_ASSERT_IMPL(a_ready_no_read, i_clk, i_rst_n, s_axis_tready, !r_rd_v)
    `LSMPQ_ASSERT_NEXT(a_insert_count, i_clk, i_rst_n,
        w_accept && s_axis_tuser[0] == OP_INSERT && r_count != CAP_CNT,
        r_count == $past(r_count) + CW'(1))
    `LSMPQ_ASSERT_NEXT(a_empty_remove, i_clk, i_rst_n,
        w_accept && s_axis_tuser[0] == OP_REMOVE && r_count == '0,
        r_state == S_RESP && r_status == ST_EMPTY)
endmodule

// ===== tb/sv/linear_scan_min_priority_queue_core_tb.sv =====
// Self-checking stream testbench for the linear-scan minimum priority queue core.
module linear_scan_min_priority_queue_core_tb;
    import lsmpq_pkg::*;

    localparam int CAPACITY    = DEF_CAPACITY;
    localparam int STALL_LIMIT = 5000;
    localparam int HOLD_CYCLES = 400;
    localparam int TAIL_CYCLES = 2 * CAPACITY + 20;
    localparam int DIR_LEN     = 22;

    typedef struct packed {
        t_status            status;
        logic [15:0]        vertex;
        logic signed [31:0] distance;
        logic [6:0]         total;
        logic               vacant;
    } t_qresult;

    typedef struct packed {
        logic        op;
        logic [15:0] vtx;
        logic [31:0] key_d;
        logic        typed;
        t_qresult    want;
    } t_dir_row;

    localparam t_qresult PREDICTED = '0;

    localparam t_dir_row DIR_ROWS [DIR_LEN] = '{
        '{OP_REMOVE, 16'h0000, 32'h00000000, 1'b1,
          '{ST_EMPTY,    16'h0000, 32'sh00000000, 7'd0, 1'b1}},
        '{OP_INSERT, 16'hFFFF, 32'h7FFFFFFF, 1'b1,
          '{ST_INSERTED, 16'h0000, 32'sh00000000, 7'd1, 1'b0}},
        '{OP_INSERT, 16'h0000, 32'h80000000, 1'b1,
          '{ST_INSERTED, 16'h0000, 32'sh00000000, 7'd2, 1'b0}},
        '{OP_REMOVE, 16'h0000, 32'h00000000, 1'b1,
          '{ST_REMOVED,  16'h0000, 32'sh80000000, 7'd1, 1'b0}},
        '{OP_REMOVE, 16'h0000, 32'h00000000, 1'b1,
          '{ST_REMOVED,  16'hFFFF, 32'sh7FFFFFFF, 7'd0, 1'b1}},
        '{OP_REMOVE, 16'h0000, 32'h00000000, 1'b1,
          '{ST_EMPTY,    16'h0000, 32'sh00000000, 7'd0, 1'b1}},
        '{OP_INSERT, 16'h0001, 32'h00000005, 1'b0, PREDICTED},
        '{OP_INSERT, 16'h0002, 32'h00000005, 1'b0, PREDICTED},
        '{OP_INSERT, 16'h0003, 32'h00000005, 1'b0, PREDICTED},
        '{OP_INSERT, 16'h0004, 32'hFFFFFFFF, 1'b0, PREDICTED},
        '{OP_INSERT, 16'h0005, 32'h00000000, 1'b0, PREDICTED},
        '{OP_REMOVE, 16'h0000, 32'h00000000, 1'b0, PREDICTED},
        '{OP_REMOVE, 16'h0000, 32'h00000000, 1'b0, PREDICTED},
        '{OP_REMOVE, 16'h0000, 32'h00000000, 1'b0, PREDICTED},
        '{OP_INSERT, 16'h0006, 32'h00000005, 1'b0, PREDICTED},
        '{OP_REMOVE, 16'h0000, 32'h00000000, 1'b0, PREDICTED},
        '{OP_REMOVE, 16'h0000, 32'h00000000, 1'b0, PREDICTED},
        '{OP_REMOVE, 16'h0000, 32'h00000000, 1'b0, PREDICTED},
        '{OP_REMOVE, 16'hAAAA, 32'h55555555, 1'b1,
          '{ST_EMPTY,    16'h0000, 32'sh00000000, 7'd0, 1'b1}},
        '{OP_INSERT, 16'h5555, 32'hAAAAAAAA, 1'b0, PREDICTED},
        '{OP_INSERT, 16'hAAAA, 32'h55555555, 1'b0, PREDICTED},
        '{OP_REMOVE, 16'h0000, 32'h00000000, 1'b0, PREDICTED}
    };

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata  = '0;   // vertex_id[15:0], key_distance[47:16]
    logic [0:0]  s_axis_tuser  = '0;   // operation[0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;         // out_vertex[15:0], out_distance[47:16],
                                       // entry_total[54:48], is_vacant[55]
    logic [1:0]  m_axis_tuser;         // status[1:0]

    logic [15:0]        pq_vtx  [CAPACITY];
    logic signed [31:0] pq_dist [CAPACITY];
    int                 pq_fill = 0;

    t_qresult pending_results [$];
    t_qresult got;
    t_qresult want;
    int       mismatch_cnt   = 0;
    int       src_idle_pct   = 0;
    int       sink_stall_pct = 0;
    logic     hold_arm       = 1'b0;
    logic     hold_done      = 1'b0;
    int       hold_left      = 0;
    int       quiet_cycles   = 0;

    linear_scan_min_priority_queue_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_qresult pq_apply(input logic op, input logic [15:0] v,
                                          input logic signed [31:0] d);
        t_qresult r;
        int       best;
        r = '0;
        if (op == OP_INSERT) begin
            if (pq_fill >= CAPACITY) begin
                r.status = ST_FULL;
            end else begin
                pq_vtx[pq_fill]  = v;
                pq_dist[pq_fill] = d;
                pq_fill++;
                r.status = ST_INSERTED;
            end
        end else if (pq_fill == 0) begin
            r.status = ST_EMPTY;
        end else begin
            best = 0;
            for (int i = 1; i < pq_fill; i++) begin
                if (pq_dist[i] <= pq_dist[best]) best = i;
            end
            r.vertex   = pq_vtx[best];
            r.distance = pq_dist[best];
            for (int i = best; i + 1 < pq_fill; i++) begin
                pq_vtx[i]  = pq_vtx[i + 1];
                pq_dist[i] = pq_dist[i + 1];
            end
            pq_fill--;
            r.status = ST_REMOVED;
        end
        r.total  = 7'(pq_fill);
        r.vacant = (pq_fill == 0);
        return r;
    endfunction

    task automatic offer(input logic op, input logic [15:0] v, input logic [31:0] d,
                         input logic typed, input t_qresult typed_want);
        t_qresult r;
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {d, v};
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        r = pq_apply(op, v, d);
        pending_results.push_back(typed ? typed_want : r);
    endtask

    task automatic run_phase(input int n, input int src_idle, input int sink_stall,
                             input int ins_pct);
        logic        op;
        logic [15:0] v;
        logic [31:0] d;
        src_idle_pct   = src_idle;
        sink_stall_pct = sink_stall;
        for (int k = 0; k < n; k++) begin
            op = ($urandom_range(99) < ins_pct) ? OP_INSERT : OP_REMOVE;
            v  = 16'($urandom_range(65535));
            case ($urandom_range(7))
                0, 1: d = 32'($signed($urandom_range(7)) - 4);
                2: d = $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000;
                default: d = $urandom;
            endcase
            offer(op, v, d, 1'b0, PREDICTED);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s mismatch: expected 0x%0h actual 0x%0h", name, exp_v, act_v);
            mismatch_cnt++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.status   = t_status'(m_axis_tuser);
            got.vertex   = m_axis_tdata[15:0];
            got.distance = m_axis_tdata[47:16];
            got.total    = m_axis_tdata[54:48];
            got.vacant   = m_axis_tdata[55];
            if (pending_results.size() == 0) begin
                $error("unexpected result: status 0x%0h", m_axis_tuser);
                mismatch_cnt++;
            end else begin
                want = pending_results.pop_front();
                check_field("status", 32'(want.status), 32'(got.status));
                check_field("out_vertex", 32'(want.vertex), 32'(got.vertex));
                check_field("out_distance", want.distance, got.distance);
                check_field("entry_total", 32'(want.total), 32'(got.total));
                check_field("is_vacant", 32'(want.vacant), 32'(got.vacant));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_arm && !hold_done) begin
            m_axis_tready <= 1'b0;
            hold_left     <= HOLD_CYCLES;
            hold_done     <= 1'b1;
        end else if (hold_left > 0) begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("linear_scan_min_priority_queue_core_tb failed");
            $finish;
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < DIR_LEN; k++) begin
            offer(DIR_ROWS[k].op, DIR_ROWS[k].vtx, DIR_ROWS[k].key_d,
                  DIR_ROWS[k].typed, DIR_ROWS[k].want);
        end

        run_phase(60, 0, 0, 60);
        run_phase(60, 83, 0, 55);
        run_phase(60, 0, 83, 50);
        run_phase(100, 36, 36, 85);
        run_phase(90, 36, 36, 10);
        hold_arm = 1'b1;
        run_phase(40, 0, 0, 70);

        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (pending_results.size() != 0) begin
            $error("%0d expected results never arrived", pending_results.size());
        end
        if (mismatch_cnt == 0 && pending_results.size() == 0) begin
            $display("linear_scan_min_priority_queue_core_tb passed");
        end else begin
            $display("linear_scan_min_priority_queue_core_tb failed");
        end
        $finish;
    end

endmodule
